// File: src/mm_pkg.sv
// Shared types and constants of the matrix multiply core.
// Holds the transaction payload structs and the controller to datapath bundles.
// Has no dependencies.
package mm_pkg;

	localparam int IDX_W     = 4;
	localparam int VAL_W     = 16;
	localparam int DIM_W     = 5;
	localparam int ACC_W     = 36;
	localparam int CFG_IDX_W = 2;
	localparam int DIM_LIMIT = 16;

	localparam logic [1:0] OP_WRITE_A = 2'd0;
	localparam logic [1:0] OP_WRITE_B = 2'd1;
	localparam logic [1:0] OP_COMPUTE = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_A_ROWS     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INNER_SIZE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_B_COLS     = 2'd2;

	localparam logic STATUS_OK  = 1'b0;
	localparam logic STATUS_ERR = 1'b1;

	typedef struct packed {
		logic [1:0]              opcode;
		logic [IDX_W-1:0]        row_index;
		logic [IDX_W-1:0]        col_index;
		logic signed [VAL_W-1:0] element_value;
	} in_t;

	typedef struct packed {
		logic [IDX_W-1:0]        out_row;
		logic [IDX_W-1:0]        out_col;
		logic signed [ACC_W-1:0] product_value;
		logic                    last_of_row;
		logic                    status;
	} out_t;

	typedef struct packed {
		logic             wr_a;
		logic             wr_b;
		logic             rd_en;
		logic             rd_first;
		logic             rd_last;
		logic             load_out;
		logic             out_err;
		logic             out_last;
		logic [IDX_W-1:0] row;
		logic [IDX_W-1:0] col;
		logic [IDX_W-1:0] k;
		logic [VAL_W-1:0] wr_data;
	} dp_cmd_t;

	typedef struct packed {
		logic acc_ready;
		logic out_free;
	} dp_status_t;

endpackage

// File: src/mm_datapath.sv
// Datapath of the matrix multiply core: element stores, multiply-accumulate unit and
// the output register. Driven by mm_ctrl through mm_pkg::dp_cmd_t; uses mm_pkg.
module mm_datapath #(
	parameter int MAX_DIM    = 16,
	parameter int DATA_WIDTH = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  mm_pkg::dp_cmd_t    cmd,
	output mm_pkg::dp_status_t status,
	output logic               out_valid,
	input  logic               out_ready,
	output mm_pkg::out_t       out_data
);

	localparam int ELEM_W = (DATA_WIDTH < mm_pkg::VAL_W) ? DATA_WIDTH : mm_pkg::VAL_W;
	localparam int DEPTH  = MAX_DIM * MAX_DIM;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int PROD_W = 2 * ELEM_W;

	function automatic logic [ADDR_W-1:0] addr_of(input logic [mm_pkg::IDX_W-1:0] r,
			input logic [mm_pkg::IDX_W-1:0] c);
		return ADDR_W'(ADDR_W'(r) * ADDR_W'(MAX_DIM) + ADDR_W'(c));
	endfunction

	logic [ELEM_W-1:0] mem_a [DEPTH];
	logic [ELEM_W-1:0] mem_b [DEPTH];

	logic [ADDR_W-1:0] a_addr;
	logic [ADDR_W-1:0] b_addr;

	logic signed [ELEM_W-1:0] a_s1;
	logic signed [ELEM_W-1:0] b_s1;
	logic                     valid_s1;
	logic                     first_s1;
	logic                     last_s1;

	logic signed [PROD_W-1:0] prod_s2;
	logic                     valid_s2;
	logic                     first_s2;
	logic                     last_s2;

	logic signed [mm_pkg::ACC_W-1:0] acc_q;
	logic                            acc_ready_q;
	logic                            out_valid_q;
	mm_pkg::out_t                    out_q;
	logic                            out_free;

	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		if (cmd.wr_a || cmd.wr_b) begin
			a_addr = addr_of(cmd.row, cmd.col);
			b_addr = addr_of(cmd.row, cmd.col);
		end else begin
			a_addr = addr_of(cmd.row, cmd.k);
			b_addr = addr_of(cmd.k, cmd.col);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_a) begin
			mem_a[a_addr] <= cmd.wr_data[ELEM_W-1:0];
		end
		a_s1 <= mem_a[a_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_b) begin
			mem_b[b_addr] <= cmd.wr_data[ELEM_W-1:0];
		end
		b_s1 <= mem_b[b_addr];
	end

	always_ff @(posedge clk) begin
		prod_s2 <= a_s1 * b_s1;
		if (valid_s2) begin
			if (first_s2) begin
				acc_q <= mm_pkg::ACC_W'(prod_s2);
			end else begin
				acc_q <= acc_q + mm_pkg::ACC_W'(prod_s2);
			end
		end
		if (cmd.load_out) begin
			out_q.out_row       <= cmd.row;
			out_q.out_col       <= cmd.col;
			out_q.product_value <= cmd.out_err ? '0 : acc_q;
			out_q.last_of_row   <= cmd.out_last;
			out_q.status        <= cmd.out_err ? mm_pkg::STATUS_ERR : mm_pkg::STATUS_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			first_s1    <= 1'b0;
			last_s1     <= 1'b0;
			valid_s2    <= 1'b0;
			first_s2    <= 1'b0;
			last_s2     <= 1'b0;
			acc_ready_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			valid_s1 <= cmd.rd_en;
			first_s1 <= cmd.rd_first;
			last_s1  <= cmd.rd_last;
			valid_s2 <= valid_s1;
			first_s2 <= first_s1;
			last_s2  <= last_s1;
			if (valid_s2 && last_s2) begin
				acc_ready_q <= 1'b1;
			end else if (cmd.load_out) begin
				acc_ready_q <= 1'b0;
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign status.acc_ready = acc_ready_q;
	assign status.out_free  = out_free;
	assign out_valid        = out_valid_q;
	assign out_data         = out_q;

endmodule

// File: src/mm_ctrl.sv
// Controller of the matrix multiply core: configuration registers, item decode and
// the sequencer over product columns and inner terms. Uses mm_pkg.
module mm_ctrl #(
	parameter int MAX_DIM = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wr_en,
	input  logic [mm_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [mm_pkg::DIM_W-1:0]       cfg_data,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  mm_pkg::in_t                    in_data,
	input  mm_pkg::dp_status_t             status,
	output mm_pkg::dp_cmd_t                cmd
);

	localparam logic [mm_pkg::DIM_W-1:0] CAP =
		mm_pkg::DIM_W'((MAX_DIM < mm_pkg::DIM_LIMIT) ? MAX_DIM : mm_pkg::DIM_LIMIT);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_ERR   = 2'd1;
	localparam logic [1:0] ST_ISSUE = 2'd2;
	localparam logic [1:0] ST_WAIT  = 2'd3;

	logic [1:0]                state_q;
	logic [1:0]                state_d;
	logic [mm_pkg::DIM_W-1:0]  a_rows_q;
	logic [mm_pkg::DIM_W-1:0]  inner_q;
	logic [mm_pkg::DIM_W-1:0]  b_cols_q;
	logic [mm_pkg::IDX_W-1:0]  row_q;
	logic [mm_pkg::IDX_W-1:0]  row_d;
	logic [mm_pkg::IDX_W-1:0]  col_q;
	logic [mm_pkg::IDX_W-1:0]  col_d;
	logic [mm_pkg::IDX_W-1:0]  k_q;
	logic [mm_pkg::IDX_W-1:0]  k_d;
	logic [mm_pkg::DIM_W-1:0]  cfg_clamped;
	logic                      accept;
	logic                      row_ok;
	logic                      col_ok_a;
	logic                      row_ok_b;
	logic                      col_ok_b;
	logic                      k_last;
	logic                      col_last;

	always_comb begin
		if (cfg_data == '0) begin
			cfg_clamped = mm_pkg::DIM_W'(1);
		end else if (cfg_data > CAP) begin
			cfg_clamped = CAP;
		end else begin
			cfg_clamped = cfg_data;
		end
	end

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;
	assign row_ok   = {1'b0, in_data.row_index} < a_rows_q;
	assign col_ok_a = {1'b0, in_data.col_index} < inner_q;
	assign row_ok_b = {1'b0, in_data.row_index} < inner_q;
	assign col_ok_b = {1'b0, in_data.col_index} < b_cols_q;
	assign k_last   = {1'b0, k_q} == inner_q - mm_pkg::DIM_W'(1);
	assign col_last = {1'b0, col_q} == b_cols_q - mm_pkg::DIM_W'(1);

	always_comb begin
		state_d = state_q;
		row_d   = row_q;
		col_d   = col_q;
		k_d     = k_q;
		cmd     = '0;
		cmd.row = row_q;
		cmd.col = col_q;
		cmd.k   = k_q;
		unique case (state_q)
			ST_IDLE: begin
				cmd.row     = in_data.row_index;
				cmd.col     = in_data.col_index;
				cmd.wr_data = in_data.element_value;
				if (accept) begin
					row_d = in_data.row_index;
					col_d = in_data.col_index;
					k_d   = '0;
					unique case (in_data.opcode)
						mm_pkg::OP_WRITE_A: begin
							if (row_ok && col_ok_a) begin
								cmd.wr_a = 1'b1;
							end else begin
								state_d = ST_ERR;
							end
						end
						mm_pkg::OP_WRITE_B: begin
							if (row_ok_b && col_ok_b) begin
								cmd.wr_b = 1'b1;
							end else begin
								state_d = ST_ERR;
							end
						end
						mm_pkg::OP_COMPUTE: begin
							col_d = '0;
							if (row_ok) begin
								state_d = ST_ISSUE;
							end else begin
								state_d = ST_ERR;
							end
						end
						default: begin
							state_d = ST_ERR;
						end
					endcase
				end
			end
			ST_ERR: begin
				if (status.out_free) begin
					cmd.load_out = 1'b1;
					cmd.out_err  = 1'b1;
					cmd.out_last = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			ST_ISSUE: begin
				cmd.rd_en    = 1'b1;
				cmd.rd_first = (k_q == '0);
				cmd.rd_last  = k_last;
				if (k_last) begin
					k_d     = '0;
					state_d = ST_WAIT;
				end else begin
					k_d = k_q + mm_pkg::IDX_W'(1);
				end
			end
			ST_WAIT: begin
				if (status.acc_ready && status.out_free) begin
					cmd.load_out = 1'b1;
					cmd.out_last = col_last;
					if (col_last) begin
						state_d = ST_IDLE;
					end else begin
						col_d   = col_q + mm_pkg::IDX_W'(1);
						state_d = ST_ISSUE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			a_rows_q <= mm_pkg::DIM_W'(1);
			inner_q  <= mm_pkg::DIM_W'(1);
			b_cols_q <= mm_pkg::DIM_W'(1);
			row_q    <= '0;
			col_q    <= '0;
			k_q      <= '0;
		end else begin
			state_q <= state_d;
			row_q   <= row_d;
			col_q   <= col_d;
			k_q     <= k_d;
			if (cfg_wr_en) begin
				unique case (cfg_index)
					mm_pkg::REG_A_ROWS:     a_rows_q <= cfg_clamped;
					mm_pkg::REG_INNER_SIZE: inner_q  <= cfg_clamped;
					mm_pkg::REG_B_COLS:     b_cols_q <= cfg_clamped;
					default: begin
					end
				endcase
			end
		end
	end

endmodule

// File: src/matrix_multiply_core.sv
// Matrix multiply core. Element writes of A and B give a result transaction only on an
// out-of-range index, which is then moved from the error state to the output register
// once the output register is free. A compute transaction is handled column by
// column: one shared multiply-accumulate unit takes one inner term per cycle from a
// single read port of each store, each product column then passes through the read,
// multiply and accumulate stages before it is moved to the output register, and the
// input is ready again in the cycle after the last column is moved.
// One transaction is handled at a time. The stores hold MAX_DIM * MAX_DIM elements
// each and have no defined content until written.
// Depends on mm_pkg, mm_ctrl and mm_datapath.
module matrix_multiply_core #(
	parameter int MAX_DIM    = 16,
	parameter int DATA_WIDTH = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_wr_en,
	input  logic [mm_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [mm_pkg::DIM_W-1:0]     cfg_data,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  mm_pkg::in_t                  in_data,
	output logic                         out_valid,
	input  logic                         out_ready,
	output mm_pkg::out_t                 out_data
);

	mm_pkg::dp_cmd_t    cmd;
	mm_pkg::dp_status_t status;

	mm_ctrl #(
		.MAX_DIM(MAX_DIM)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.status    (status),
		.cmd       (cmd)
	);

	mm_datapath #(
		.MAX_DIM   (MAX_DIM),
		.DATA_WIDTH(DATA_WIDTH)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

// File: dv/matrix_multiply_core_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for matrix_multiply_core: loads A and B element by element, requests
// product rows and checks every product element and error result against a behavioral mirror of the core.
// Depends on mm_pkg and matrix_multiply_core.
module matrix_multiply_core_tb;

	localparam logic [1:0] OP_UNDEFINED = 2'd3;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int HOLD_CYCLES = 600;
	localparam int SETTLE_CYCLES = 8;
	localparam int DRAIN_CYCLES = 40;
	localparam int RANDOM_OPS = 40;
	localparam int PHASES = 6;
	localparam int PRESSURE_PHASE = 4;

	localparam int PHASE_DIMS [PHASES][3] = '{
		'{3, 4, 5}, '{16, 1, 16}, '{1, 16, 1}, '{0, 0, 0}, '{31, 2, 31}, '{5, 7, 3}
	};

	logic                         clk = 1'b0;
	logic                         arst_n = 1'b0;
	logic                         cfg_wr_en = 1'b0;
	logic [mm_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [mm_pkg::DIM_W-1:0]     cfg_data = '0;
	logic                         in_valid = 1'b0;
	logic                         in_ready;
	mm_pkg::in_t                  in_data = '0;
	logic                         out_valid;
	logic                         out_ready = 1'b0;
	mm_pkg::out_t                 out_data;

	mm_pkg::in_t              op_queue [$];
	mm_pkg::out_t             due_c_elements [$];
	logic [mm_pkg::DIM_W-1:0] dim_a_rows = 5'd1;
	logic [mm_pkg::DIM_W-1:0] dim_inner = 5'd1;
	logic [mm_pkg::DIM_W-1:0] dim_b_cols = 5'd1;
	logic signed [mm_pkg::VAL_W-1:0] a_mirror [mm_pkg::DIM_LIMIT][mm_pkg::DIM_LIMIT];
	logic signed [mm_pkg::VAL_W-1:0] b_mirror [mm_pkg::DIM_LIMIT][mm_pkg::DIM_LIMIT];
	int ops_sent = 0;
	int ops_accepted = 0;
	int mismatch_count = 0;
	int quiet_cycles = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	bit hold_arm = 1'b0;
	bit hold_taken;
	int hold_left;

	matrix_multiply_core u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic int eff_dim(logic [mm_pkg::DIM_W-1:0] raw);
		if (raw == 0) return 1;
		if (raw > mm_pkg::DIM_LIMIT) return mm_pkg::DIM_LIMIT;
		return int'(raw);
	endfunction

	function automatic mm_pkg::in_t make_op(logic [1:0] op, int r, int c,
			logic signed [mm_pkg::VAL_W-1:0] v);
		mm_pkg::in_t t;
		t.opcode = op;
		t.row_index = r[mm_pkg::IDX_W-1:0];
		t.col_index = c[mm_pkg::IDX_W-1:0];
		t.element_value = v;
		return t;
	endfunction

	function automatic logic signed [mm_pkg::VAL_W-1:0] rand_elem();
		unique case ($urandom_range(9))
			0: return 16'sh8000;
			1: return 16'sh7fff;
			2: return '0;
			3: return -16'sd1;
			default: return mm_pkg::VAL_W'($urandom());
		endcase
	endfunction

	function automatic void push_error(int r, int c);
		mm_pkg::out_t e;
		e.out_row = r[mm_pkg::IDX_W-1:0];
		e.out_col = c[mm_pkg::IDX_W-1:0];
		e.product_value = '0;
		e.last_of_row = 1'b1;
		e.status = mm_pkg::STATUS_ERR;
		due_c_elements.push_back(e);
	endfunction

	function automatic void mirror_matrix_op(mm_pkg::in_t t);
		int ar, kn, bc, r, c;
		longint acc;
		mm_pkg::out_t e;
		ar = eff_dim(dim_a_rows);
		kn = eff_dim(dim_inner);
		bc = eff_dim(dim_b_cols);
		r = int'(t.row_index);
		c = int'(t.col_index);
		unique case (t.opcode)
			mm_pkg::OP_WRITE_A: begin
				if (r < ar && c < kn) a_mirror[r][c] = t.element_value;
				else push_error(r, c);
			end
			mm_pkg::OP_WRITE_B: begin
				if (r < kn && c < bc) b_mirror[r][c] = t.element_value;
				else push_error(r, c);
			end
			mm_pkg::OP_COMPUTE: begin
				if (r >= ar) begin
					push_error(r, 0);
				end else begin
					for (int j = 0; j < bc; j++) begin
						acc = 0;
						for (int k = 0; k < kn; k++)
							acc += longint'(a_mirror[r][k]) * longint'(b_mirror[k][j]);
						e.out_row = r[mm_pkg::IDX_W-1:0];
						e.out_col = j[mm_pkg::IDX_W-1:0];
						e.product_value = acc[mm_pkg::ACC_W-1:0];
						e.last_of_row = (j == bc - 1);
						e.status = mm_pkg::STATUS_OK;
						due_c_elements.push_back(e);
					end
				end
			end
			default: push_error(r, c);
		endcase
	endfunction

	function automatic void check_field(string name, logic [63:0] exp_v, logic [63:0] got_v);
		if (got_v !== exp_v) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, got_v);
			mismatch_count++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				mirror_matrix_op(in_data);
				ops_accepted++;
			end
			if (!in_valid || in_ready) begin
				if (op_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					in_valid <= 1'b1;
					in_data <= op_queue.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			hold_left <= 0;
			hold_taken <= 1'b0;
		end else if (hold_left != 0) begin
			out_ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_arm && !hold_taken) begin
			out_ready <= 1'b0;
			hold_left <= HOLD_CYCLES;
			hold_taken <= 1'b1;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		mm_pkg::out_t e;
		if (arst_n && out_valid && out_ready) begin
			if (due_c_elements.size() == 0) begin
				$display("%0t: unexpected result transaction, expected none, actual %p",
					$time, out_data);
				mismatch_count++;
			end else begin
				e = due_c_elements.pop_front();
				check_field("out_row", 64'(e.out_row), 64'(out_data.out_row));
				check_field("out_col", 64'(e.out_col), 64'(out_data.out_col));
				check_field("product_value", 64'(e.product_value),
					64'(out_data.product_value));
				check_field("last_of_row", 64'(e.last_of_row), 64'(out_data.last_of_row));
				check_field("status", 64'(e.status), 64'(out_data.status));
			end
		end
	end

	always @(posedge clk) begin
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end else if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic queue_op(mm_pkg::in_t t);
		op_queue.push_back(t);
		ops_sent++;
	endtask

	task automatic wait_drained();
		while (ops_accepted != ops_sent || due_c_elements.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_dims(int a, int k, int b);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= mm_pkg::REG_A_ROWS;
		cfg_data <= a[mm_pkg::DIM_W-1:0];
		@(posedge clk);
		cfg_index <= mm_pkg::REG_INNER_SIZE;
		cfg_data <= k[mm_pkg::DIM_W-1:0];
		@(posedge clk);
		cfg_index <= mm_pkg::REG_B_COLS;
		cfg_data <= b[mm_pkg::DIM_W-1:0];
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		dim_a_rows = a[mm_pkg::DIM_W-1:0];
		dim_inner = k[mm_pkg::DIM_W-1:0];
		dim_b_cols = b[mm_pkg::DIM_W-1:0];
	endtask

	task automatic set_idling(int mode);
		unique case (mode)
			1: begin send_idle_pct = 45; recv_stall_pct = 0; end
			2: begin send_idle_pct = 0; recv_stall_pct = 45; end
			3: begin send_idle_pct = 27; recv_stall_pct = 27; end
			default: begin send_idle_pct = 0; recv_stall_pct = 0; end
		endcase
	endtask

	initial begin
		int ar, kn, bc, roll;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: extreme products, every error path and the undefined opcode.
		set_idling(0);
		write_dims(1, 2, 1);
		queue_op(make_op(mm_pkg::OP_WRITE_A, 0, 0, 16'sh8000));
		queue_op(make_op(mm_pkg::OP_WRITE_A, 0, 1, 16'sh8000));
		queue_op(make_op(mm_pkg::OP_WRITE_B, 0, 0, 16'sh8000));
		queue_op(make_op(mm_pkg::OP_WRITE_B, 1, 0, 16'sh8000));
		queue_op(make_op(mm_pkg::OP_COMPUTE, 0, 15, '0));
		queue_op(make_op(mm_pkg::OP_WRITE_A, 0, 0, 16'sh7fff));
		queue_op(make_op(mm_pkg::OP_COMPUTE, 0, 0, '0));
		queue_op(make_op(mm_pkg::OP_WRITE_B, 0, 0, 16'sh7fff));
		queue_op(make_op(mm_pkg::OP_COMPUTE, 0, 0, '0));
		queue_op(make_op(mm_pkg::OP_WRITE_A, 1, 0, 16'sh7fff));
		queue_op(make_op(mm_pkg::OP_WRITE_A, 0, 2, 16'sh7fff));
		queue_op(make_op(mm_pkg::OP_WRITE_B, 2, 0, -16'sd1));
		queue_op(make_op(mm_pkg::OP_WRITE_B, 0, 1, -16'sd1));
		queue_op(make_op(mm_pkg::OP_WRITE_A, 15, 15, 16'sh5555));
		queue_op(make_op(mm_pkg::OP_WRITE_B, 15, 15, 16'shaaaa));
		queue_op(make_op(mm_pkg::OP_COMPUTE, 1, 7, '0));
		queue_op(make_op(mm_pkg::OP_COMPUTE, 15, 15, '0));
		queue_op(make_op(OP_UNDEFINED, 15, 15, -16'sd1));
		queue_op(make_op(OP_UNDEFINED, 0, 0, '0));
		queue_op(make_op(mm_pkg::OP_WRITE_A, 0, 0, '0));
		queue_op(make_op(mm_pkg::OP_WRITE_A, 0, 1, -16'sd1));
		queue_op(make_op(mm_pkg::OP_COMPUTE, 0, 0, '0));

		for (int p = 0; p < PHASES; p++) begin
			wait_drained();
			repeat (SETTLE_CYCLES) @(posedge clk);
			write_dims(PHASE_DIMS[p][0], PHASE_DIMS[p][1], PHASE_DIMS[p][2]);
			set_idling(p % 4);
			ar = eff_dim(dim_a_rows);
			kn = eff_dim(dim_inner);
			bc = eff_dim(dim_b_cols);

			// Load every element a product row can read before any row is requested.
			for (int r = 0; r < ar; r++)
				for (int c = 0; c < kn; c++)
					queue_op(make_op(mm_pkg::OP_WRITE_A, r, c, rand_elem()));
			for (int r = 0; r < kn; r++)
				for (int c = 0; c < bc; c++)
					queue_op(make_op(mm_pkg::OP_WRITE_B, r, c, rand_elem()));

			if (p == PRESSURE_PHASE) begin
				while (op_queue.size() != 0)
					@(posedge clk);
				hold_arm = 1'b1;
			end

			for (int i = 0; i < RANDOM_OPS; i++) begin
				roll = $urandom_range(99);
				if (roll < 30)
					queue_op(make_op(mm_pkg::OP_WRITE_A, $urandom_range(ar - 1),
						$urandom_range(kn - 1), rand_elem()));
				else if (roll < 55)
					queue_op(make_op(mm_pkg::OP_WRITE_B, $urandom_range(kn - 1),
						$urandom_range(bc - 1), rand_elem()));
				else if (roll < 85)
					queue_op(make_op(mm_pkg::OP_COMPUTE, $urandom_range(ar - 1),
						$urandom_range(15), rand_elem()));
				else
					queue_op(make_op(2'($urandom_range(3)), $urandom_range(15),
						$urandom_range(15), rand_elem()));
			end
		end

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

// File: files.f
src/mm_pkg.sv
src/mm_datapath.sv
src/mm_ctrl.sv
src/matrix_multiply_core.sv
dv/matrix_multiply_core_tb.sv
